/* hdl/tolerance_value_group_labeler_defines.svh */
// Assertion macros shared by the labeler RTL.
`ifndef TOLERANCE_VALUE_GROUP_LABELER_DEFINES_SVH
`define TOLERANCE_VALUE_GROUP_LABELER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define TVGL_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition in one cycle implies a result in the next.
`define TVGL_ASSERT_NEXT(name, cond, nxt, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) else $error(msg);

`endif

/* hdl/tvgl_pkg.sv */
// Types and constants of the tolerance value group labeler.
package tvgl_pkg;

   localparam int VALUE_W       = 32;
   localparam int TOL_W         = 32;
   localparam int GROUP_ID_W    = 6;
   localparam int GROUP_TOTAL_W = 7;

   // Steps of the shared distance unit.
   typedef struct packed {
      logic load;    // take abs differences of the two values
      logic sq_re;   // square the real difference
      logic sq_im;   // square the imaginary difference
   } dist_ctl_type;

endpackage

/* hdl/tvgl_store.sv */
// Entry table: stored values and labels, one write and one registered read port.
module tvgl_store #(
   parameter int DEPTH = 64,
   parameter int DW    = 70
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DW-1:0]            wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DW-1:0]            rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/tvgl_dist.sv */
// Squared complex distance unit: one shared 32x32 squarer, stepped by the sequencer.
module tvgl_dist (
   input  logic                                 clock,
   input  tvgl_pkg::dist_ctl_type               ctl,
   input  logic signed [tvgl_pkg::VALUE_W-1:0]  a_re,
   input  logic signed [tvgl_pkg::VALUE_W-1:0]  a_im,
   input  logic signed [tvgl_pkg::VALUE_W-1:0]  b_re,
   input  logic signed [tvgl_pkg::VALUE_W-1:0]  b_im,
   input  logic [tvgl_pkg::TOL_W-1:0]           tol,
   output logic                                 hit
);

   localparam int VW = tvgl_pkg::VALUE_W;

   logic signed [VW:0]   diff_re;
   logic signed [VW:0]   diff_im;
   logic signed [VW:0]   mag_re;
   logic signed [VW:0]   mag_im;
   logic [VW-1:0]        dr_ff;
   logic [VW-1:0]        di_ff;
   logic [VW-1:0]        sq_op;
   logic [2*VW-1:0]      sq_prod;
   logic [2*VW-1:0]      sr_ff;
   logic [2*VW-1:0]      si_ff;
   logic [VW:0]          sum_low;

   // exact 33-bit differences; magnitude always fits 32 bits unsigned
   assign diff_re = {a_re[VW-1], a_re} - {b_re[VW-1], b_re};
   assign diff_im = {a_im[VW-1], a_im} - {b_im[VW-1], b_im};
   assign mag_re  = diff_re[VW] ? (VW+1)'(-diff_re) : diff_re;
   assign mag_im  = diff_im[VW] ? (VW+1)'(-diff_im) : diff_im;

   assign sq_op   = ctl.sq_im ? di_ff : dr_ff;
   assign sq_prod = sq_op * sq_op;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         dr_ff <= mag_re[VW-1:0];
         di_ff <= mag_im[VW-1:0];
      end
      if (ctl.sq_re) begin
         sr_ff <= sq_prod;
      end
      if (ctl.sq_im) begin
         si_ff <= sq_prod;
      end
   end

   // a sum below tol implies each square below tol
   assign sum_low = {1'b0, sr_ff[VW-1:0]} + {1'b0, si_ff[VW-1:0]};
   assign hit = (sr_ff[2*VW-1:VW] == '0) && (si_ff[2*VW-1:VW] == '0) &&
                (sum_low < {1'b0, tol});

endmodule

/* hdl/tolerance_value_group_labeler.sv */
// Top level of the tolerance value group labeler: sequencer, registers and ports.
// Each word on req_ is a complex Q16.16 value; it is compared in arrival order with
// the values stored for the current matrix and takes the label of the first one
// whose squared distance is strictly below the csr_ tolerance, else a new label.
// A single shared squarer walks the table, stepping through read, difference, square of
// the real part, square of the imaginary part and compare for each entry compared;
// an item's result waits for the previous word to leave the output register;
// req_tready is high only between items. One result word per item leaves on rsp_
// through an output register, so a new item can start while the previous result
// waits. An item that matches no entry of a full table returns id 0 with the
// overflow flag, and a full table stores nothing. req_tuser set clears the table
// before that item.
`include "tolerance_value_group_labeler_defines.svh"

module tolerance_value_group_labeler #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] value_re, [63:32] value_im
   input  logic [0:0]  req_tuser,   // [0] starts_matrix
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [5:0] group_id, [12:6] group_total, [15:13] zero
   output logic [0:0]  rsp_tuser,   // [0] table_overflow
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data     // tolerance_squared
);

   localparam int VW = tvgl_pkg::VALUE_W;
   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int DW = 2 * VW + AW;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RD   = 3'd1;
   localparam logic [2:0] ST_DIFF = 3'd2;
   localparam logic [2:0] ST_SQR  = 3'd3;
   localparam logic [2:0] ST_SQI  = 3'd4;
   localparam logic [2:0] ST_CMP  = 3'd5;
   localparam logic [2:0] ST_FIN  = 3'd6;

   logic [2:0]                          state_ff, state_in;
   logic [CW-1:0]                       k_ff, k_in;
   logic [CW-1:0]                       entry_count_ff, entry_count_in;
   logic [CW-1:0]                       label_count_ff, label_count_in;
   logic [tvgl_pkg::TOL_W-1:0]          tol_ff, tol_in;
   logic                                matched_ff, matched_in;
   logic [AW-1:0]                       match_label_ff, match_label_in;
   logic signed [VW-1:0]                val_re_ff, val_re_in;
   logic signed [VW-1:0]                val_im_ff, val_im_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [tvgl_pkg::GROUP_ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [tvgl_pkg::GROUP_TOTAL_W-1:0]  rsp_total_ff, rsp_total_in;
   logic                                rsp_ovf_ff, rsp_ovf_in;

   tvgl_pkg::dist_ctl_type dist_ctl;
   logic                   hit;
   logic                   rd_en;
   logic                   wr_en;
   logic [DW-1:0]          rd_data;
   logic [DW-1:0]          wr_data;
   logic signed [VW-1:0]   rd_re;
   logic signed [VW-1:0]   rd_im;
   logic [AW-1:0]          rd_label;
   logic                   full;
   logic                   out_free;
   logic [AW-1:0]          fin_id;
   logic                   fin_ovf;
   logic [CW-1:0]          fin_label_count;

   assign rd_re    = rd_data[VW-1:0];
   assign rd_im    = rd_data[2*VW-1:VW];
   assign rd_label = rd_data[DW-1:2*VW];

   assign full     = (entry_count_ff == CW'(MAX_ENTRIES));
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      fin_ovf         = 1'b0;
      fin_label_count = label_count_ff;
      if (matched_ff) begin
         fin_id = match_label_ff;
      end else if (full) begin
         fin_id  = '0;
         fin_ovf = 1'b1;
      end else begin
         fin_id          = label_count_ff[AW-1:0];
         fin_label_count = CW'(label_count_ff + 1'b1);
      end
   end

   assign wr_data = {fin_id, val_im_ff, val_re_ff};

   always_comb begin
      state_in       = state_ff;
      k_in           = k_ff;
      entry_count_in = entry_count_ff;
      label_count_in = label_count_ff;
      matched_in     = matched_ff;
      match_label_in = match_label_ff;
      val_re_in      = val_re_ff;
      val_im_in      = val_im_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      rsp_valid_in   = rsp_tready ? 1'b0 : rsp_valid_ff;
      tol_in         = csr_valid ? csr_data : tol_ff;
      dist_ctl       = '0;
      rd_en          = 1'b0;
      wr_en          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               val_re_in  = req_tdata[31:0];
               val_im_in  = req_tdata[63:32];
               k_in       = '0;
               matched_in = 1'b0;
               if (req_tuser[0]) begin
                  entry_count_in = '0;
                  label_count_in = '0;
               end
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            if (k_ff == entry_count_ff) begin
               state_in = ST_FIN;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            dist_ctl.load = 1'b1;
            state_in      = ST_SQR;
         end
         ST_SQR: begin
            dist_ctl.sq_re = 1'b1;
            state_in       = ST_SQI;
         end
         ST_SQI: begin
            dist_ctl.sq_im = 1'b1;
            state_in       = ST_CMP;
         end
         ST_CMP: begin
            if (hit) begin
               matched_in     = 1'b1;
               match_label_in = rd_label;
               state_in       = ST_FIN;
            end else begin
               k_in     = CW'(k_ff + 1'b1);
               state_in = ST_RD;
            end
         end
         ST_FIN: begin
            // hold here until the output register can take the word
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_id_in      = tvgl_pkg::GROUP_ID_W'(fin_id);
               rsp_total_in   = tvgl_pkg::GROUP_TOTAL_W'(fin_label_count);
               rsp_ovf_in     = fin_ovf;
               label_count_in = fin_label_count;
               if (!full) begin
                  wr_en          = 1'b1;
                  entry_count_in = CW'(entry_count_ff + 1'b1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         label_count_ff <= '0;
         tol_ff         <= tvgl_pkg::TOL_W'(1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         label_count_ff <= label_count_in;
         tol_ff         <= tol_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff           <= k_in;
      matched_ff     <= matched_in;
      match_label_ff <= match_label_in;
      val_re_ff      <= val_re_in;
      val_im_ff      <= val_im_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

   tvgl_store #(
      .DEPTH (MAX_ENTRIES),
      .DW    (DW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (entry_count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (k_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   tvgl_dist u_dist (
      .clock (clock),
      .ctl   (dist_ctl),
      .a_re  (rd_re),
      .a_im  (rd_im),
      .b_re  (val_re_ff),
      .b_im  (val_im_ff),
      .tol   (tol_ff),
      .hit   (hit)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_total_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_ovf_ff;
   assign csr_ready  = 1'b1;

   `TVGL_ASSERT(a_labels_le_entries, label_count_ff <= entry_count_ff, "more labels than entries")
   `TVGL_ASSERT(a_no_write_when_full, !(wr_en && full), "table write while full")
   `TVGL_ASSERT(a_read_in_range, !rd_en || (k_ff < entry_count_ff), "read past stored entries")
   `TVGL_ASSERT_NEXT(a_result_posted, (state_ff == ST_FIN) && out_free, rsp_tvalid && req_tready, "result word not posted")

endmodule

/* bench/label_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the labeler: mirrors the value table, predicts each result word, compares.
module label_checker #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] value_re, [63:32] value_im
   input  logic [0:0]  req_tuser,   // [0] starts_matrix
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [5:0] group_id, [12:6] group_total, [15:13] zero
   input  logic [0:0]  rsp_tuser,   // [0] table_overflow
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [31:0] csr_data,    // tolerance_squared
   output int          mismatch_count,
   output int          pending_words
);

   localparam int VALUE_W   = tvgl_pkg::VALUE_W;
   localparam int TOL_W     = tvgl_pkg::TOL_W;
   localparam int ID_W      = tvgl_pkg::GROUP_ID_W;
   localparam int TOTAL_W   = tvgl_pkg::GROUP_TOTAL_W;
   localparam int TOTAL_LSB = ID_W;
   localparam int PAD_LSB   = ID_W + TOTAL_W;

   typedef struct packed {
      logic [ID_W-1:0]    group_id;
      logic [TOTAL_W-1:0] group_total;
      logic               table_overflow;
   } label_word_type;

   logic [VALUE_W-1:0] table_re    [TABLE_DEPTH];
   logic [VALUE_W-1:0] table_im    [TABLE_DEPTH];
   int                 table_label [TABLE_DEPTH];
   int                 entry_total;
   int                 label_total;
   logic [TOL_W-1:0]   tolerance;
   label_word_type     expected_labels [$];

   // Exact squared distance: 33-bit differences, 67-bit sum, no rounding.
   function automatic bit is_near(input logic [VALUE_W-1:0] re_a, im_a, re_b, im_b,
                                  input logic [TOL_W-1:0] limit);
      logic signed [VALUE_W:0]   d_re, d_im;
      logic [VALUE_W:0]          a_re, a_im;
      logic [2*VALUE_W+2:0]      dist_sq;
      d_re = $signed({re_a[VALUE_W-1], re_a}) - $signed({re_b[VALUE_W-1], re_b});
      d_im = $signed({im_a[VALUE_W-1], im_a}) - $signed({im_b[VALUE_W-1], im_b});
      a_re = d_re[VALUE_W] ? -d_re : d_re;
      a_im = d_im[VALUE_W] ? -d_im : d_im;
      dist_sq = a_re * a_re + a_im * a_im;
      return dist_sq < limit;
   endfunction

   // First match in arrival order wins; a full table stores nothing.
   function automatic label_word_type label_value(input logic [VALUE_W-1:0] re, im,
                                                  input logic fresh);
      label_word_type word;
      int             id;
      bit             matched;
      id = 0;
      matched = 1'b0;
      word.table_overflow = 1'b0;
      if (fresh) begin
         entry_total = 0;
         label_total = 0;
      end
      for (int k = 0; k < entry_total; k++) begin
         if (!matched && is_near(table_re[k], table_im[k], re, im, tolerance)) begin
            id = table_label[k];
            matched = 1'b1;
         end
      end
      if (entry_total >= TABLE_DEPTH) begin
         if (!matched) begin
            id = 0;
            word.table_overflow = 1'b1;
         end
      end else begin
         if (!matched) begin
            id = label_total;
            label_total++;
         end
         table_re[entry_total] = re;
         table_im[entry_total] = im;
         table_label[entry_total] = id;
         entry_total++;
      end
      word.group_id = id[ID_W-1:0];
      word.group_total = label_total[TOTAL_W-1:0];
      return word;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      label_word_type want;
      if (reset) begin
         entry_total = 0;
         label_total = 0;
         tolerance = TOL_W'(1);
         expected_labels.delete();
      end else begin
         // result first: a word leaving now belongs to an earlier item
         if (rsp_tvalid && rsp_tready) begin
            if (expected_labels.size() == 0) begin
               report_mismatch("result word with nothing expected", rsp_tdata, 0);
            end else begin
               want = expected_labels.pop_front();
               if (rsp_tdata[ID_W-1:0] !== want.group_id)
                  report_mismatch("group_id", rsp_tdata[ID_W-1:0], want.group_id);
               if (rsp_tdata[PAD_LSB-1:TOTAL_LSB] !== want.group_total)
                  report_mismatch("group_total", rsp_tdata[PAD_LSB-1:TOTAL_LSB],
                                  want.group_total);
               if (rsp_tdata[15:PAD_LSB] !== '0)
                  report_mismatch("tdata padding", rsp_tdata[15:PAD_LSB], 0);
               if (rsp_tuser[0] !== want.table_overflow)
                  report_mismatch("table_overflow", rsp_tuser[0], want.table_overflow);
            end
         end
         if (csr_valid && csr_ready)
            tolerance = csr_data;
         if (req_tvalid && req_tready)
            expected_labels.push_back(label_value(req_tdata[31:0], req_tdata[63:32],
                                                  req_tuser[0]));
      end
      pending_words = expected_labels.size();
   end

endmodule

/* bench/tb_tolerance_value_group_labeler.sv */
`timescale 1ns / 100ps
// Testbench top for the labeler: clock, reset, stimulus, flow control and verdict.
module tb_tolerance_value_group_labeler;

   localparam int TABLE_DEPTH = 64;
   localparam int ITEM_TARGET = 1900;
   localparam int DIRECTED    = 25;
   localparam int PHASES      = 8;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int TAIL_CYCLES = 5 * TABLE_DEPTH + 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // [31:0] value_re, [63:32] value_im
   logic [0:0]  req_tuser = '0;   // [0] starts_matrix
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [5:0] group_id, [12:6] group_total, [15:13] zero
   logic [0:0]  rsp_tuser;        // [0] table_overflow
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;    // tolerance_squared

   int gap_pct = 0;
   int stall_pct = 0;
   int sent_count = 0;
   int cycle_count = 0;
   int mismatch_count;
   int pending_words;

   tolerance_value_group_labeler #(.MAX_ENTRIES(TABLE_DEPTH)) uut (.*);

   label_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side back-pressure in bursts
   always @(negedge clock) begin
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         rsp_tready = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      rsp_tready = 1'b1;
   end

   function automatic logic [31:0] corner_value();
      case ($urandom_range(0, 5))
         0: return 32'h0000_0000;
         1: return 32'h0000_0001;
         2: return 32'hFFFF_FFFF;
         3: return 32'h7FFF_FFFF;
         4: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // called at a falling edge, returns at a falling edge with valid low
   task automatic send_value(input logic [31:0] re, im, input logic fresh);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
         repeat ($urandom_range(1, 15)) @(negedge clock);
      req_tdata = {im, re};
      req_tuser = fresh;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
      sent_count++;
   endtask

   task automatic write_tolerance(input logic [31:0] value);
      while (pending_words != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_data = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // values drawn mostly from a small pool with jitter so near-matches are common
   task automatic run_matrix(input int length, input bit fresh, input int jitter);
      logic [31:0] pool_re [8];
      logic [31:0] pool_im [8];
      logic [31:0] re, im;
      int          pool_size;
      int          pick;
      int          kind;
      pool_size = $urandom_range(1, 8);
      for (int p = 0; p < pool_size; p++) begin
         pool_re[p] = ($urandom_range(0, 3) == 0) ? corner_value() : $urandom;
         pool_im[p] = ($urandom_range(0, 3) == 0) ? corner_value() : $urandom;
      end
      for (int n = 0; n < length; n++) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            re = $urandom;
            im = $urandom;
         end else if (kind == 1) begin
            re = corner_value();
            im = corner_value();
         end else begin
            pick = $urandom_range(0, pool_size - 1);
            re = pool_re[pick];
            im = pool_im[pick];
            if ($urandom_range(0, 2) != 0) begin
               re = re + 32'(int'($urandom_range(0, 4 * jitter)) - 2 * jitter);
               im = im + 32'(int'($urandom_range(0, 4 * jitter)) - 2 * jitter);
            end
         end
         send_value(re, im, (n == 0) ? fresh : ($urandom_range(0, 63) == 0));
      end
   endtask

   initial begin
      logic [31:0] tol;
      int          jitter;
      int          length;
      int          phase_end;
      bit          long_first;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset tolerance (exact match only), extremes, first word without start
      gap_pct = 20;
      stall_pct = 5;
      send_value(32'h0000_0000, 32'h0000_0000, 1'b0);
      send_value(32'h0000_0000, 32'h0000_0000, 1'b0);
      send_value(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_value(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      send_value(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_value(32'h8000_0000, 32'h8000_0000, 1'b0);
      send_value(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_value(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_value(32'h0000_0001, 32'h0000_0001, 1'b0);
      send_value(32'h0000_0000, 32'h0000_0001, 1'b0);
      send_value(32'h0000_0000, 32'h0000_0000, 1'b1);
      send_value(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
      // distance 1 now matches, distance 2 does not
      write_tolerance(32'd2);
      send_value(32'h0000_0000, 32'h0000_0001, 1'b0);
      send_value(32'h0000_0001, 32'h0000_0001, 1'b0);
      send_value(32'h0000_0001, 32'h0000_0000, 1'b0);
      // zero tolerance: even equal values get new labels
      write_tolerance(32'd0);
      send_value(32'h0000_0000, 32'h0000_0000, 1'b1);
      send_value(32'h0000_0000, 32'h0000_0000, 1'b0);
      // widest tolerance: just under one unit apart matches, exactly one unit does not
      write_tolerance(32'hFFFF_FFFF);
      send_value(32'h0000_0000, 32'h0000_0000, 1'b1);
      send_value(32'h0000_FFFF, 32'h0000_0000, 1'b0);
      send_value(32'h0000_0000, 32'h0001_0000, 1'b0);
      send_value(32'h0000_FFFF, 32'h0000_FFFF, 1'b0);
      send_value(32'h8000_0000, 32'h8000_0000, 1'b0);
      send_value(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: tol = 32'hFFFF_FFFF;
            1: tol = 32'h0000_0000;
            2: tol = 32'h0000_0001;
            3: tol = 32'h0000_0002;
            4: tol = $urandom_range(3, 32'h0000_FFFF);
            5: tol = $urandom | 32'h8000_0000;
            6: tol = 32'h0001_0000;
            default: tol = $urandom;
         endcase
         write_tolerance(tol);
         jitter = 1 << (($clog2(tol) + 1) / 2);
         if (phase == PHASES - 1) begin
            gap_pct = 0;
            stall_pct = 0;
         end else begin
            case ($urandom_range(0, 2))
               0: gap_pct = 0;
               1: gap_pct = 10;
               default: gap_pct = 35;
            endcase
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 3;
               default: stall_pct = 12;
            endcase
         end
         // zero and exact tolerance get a matrix that runs past a full table
         long_first = (phase == 1 || phase == 2);
         phase_end = DIRECTED + (phase + 1) * ((ITEM_TARGET - DIRECTED) / PHASES);
         while (sent_count < phase_end) begin
            if (long_first)
               length = 72;
            else if ($urandom_range(0, 11) == 0)
               length = $urandom_range(60, 72);
            else
               length = $urandom_range(1, 24);
            // a phase may carry on with the table left by the previous one
            run_matrix(length, long_first || sent_count != 0 && $urandom_range(0, 3) != 0,
                       jitter);
            long_first = 1'b0;
         end
      end

      while (pending_words != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
